/* hw/rtl/rbm_pkg.sv */
`default_nettype none

package rbm_pkg;

    // Field widths of one bus access and of one translation result.
    localparam int unsigned ADDR_W     = 16;
    localparam int unsigned DATA_W     = 8;
    localparam int unsigned MAP_W      = 21;
    localparam int unsigned IN_TDATA_W = 24;
    localparam int unsigned OUT_TDATA_W = 24;

    // Configuration register widths and indexes.
    localparam int unsigned ROM_COUNT_W = 8;
    localparam int unsigned RAM_COUNT_W = 3;
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_ROM_BANK_COUNT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RAM_BANK_COUNT = 1'd1;

    localparam logic [ROM_COUNT_W-1:0] ROM_COUNT_RESET = 8'd2;
    localparam logic [RAM_COUNT_W-1:0] RAM_COUNT_RESET = 3'd0;

    // Banking thresholds: upper bits matter only above these counts.
    localparam logic [ROM_COUNT_W-1:0] ROM_COUNT_SMALL_MAX = 8'h20;
    localparam logic [RAM_COUNT_W-1:0] RAM_COUNT_SMALL_MAX = 3'd1;

    // Access kind carried in tuser.
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Value in the low nibble that enables external RAM.
    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

    // Address regions, decoded from address bits 15:13.
    localparam logic [2:0] REGION_RAM_ENABLE = 3'd0;
    localparam logic [2:0] REGION_ROM_BANK   = 3'd1;
    localparam logic [2:0] REGION_UPPER_BANK = 3'd2;
    localparam logic [2:0] REGION_MODE       = 3'd3;
    localparam logic [2:0] REGION_EXT_RAM    = 3'd5;

endpackage : rbm_pkg

`default_nettype wire

/* hw/rtl/rom_ram_bank_mapper.sv */
// Cartridge ROM/RAM bank mapper.
// Input channel (s_axis_*): one CPU bus transaction per item. tuser holds the
// access kind (0 read, 1 write); tdata holds the bus address and write data.
// Output channel (m_axis_*): one result per input transaction, in order.
// tuser flags whether the access was handled and whether it targets RAM;
// tdata holds the translated ROM or RAM byte address.
// Writes to the ROM range load the RAM enable, low ROM bank, upper bank bits
// and banking mode; the next transaction already sees the new values.
// The result passes through one input register, then the decode and bank
// logic into the result register. Throughput is one transaction per cycle
// while the receiver takes results; the logic is masks and muxes only.
// When the receiver stalls, the result register holds; an empty input register
// still takes one more transaction, then tready drops until tready returns.
// Configuration (cfg_*) sets the ROM and RAM bank counts; write it only while
// no transaction is in flight. Reset clears both stages and loads RAM disabled,
// low bank 1, upper bits 0, mode 0, 2 ROM banks and no RAM banks.
`default_nettype none

module rom_ram_bank_mapper (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    // Configuration write port.
    input  wire logic                               cfg_we,
    input  wire logic [rbm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [rbm_pkg::CFG_DATA_W-1:0]     cfg_data,

    // Bus access stream.
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [15:0] bus_address, [23:16] write_data
    input  wire logic [rbm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [0] req_type
    input  wire logic                               s_axis_tuser,

    // Translation result stream.
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [20:0] mapped_address, [23:21] zero
    output logic [rbm_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    // [0] accepted, [1] to_ram
    output logic [1:0]                              m_axis_tuser
);
    import rbm_pkg::*;

    // Configuration registers.
    logic [ROM_COUNT_W-1:0] rom_bank_count_reg;
    logic [RAM_COUNT_W-1:0] ram_bank_count_reg;

    // Bank state.
    logic       ram_enabled_reg;
    logic [4:0] low_rom_bank_reg;
    logic [1:0] upper_bank_bits_reg;
    logic       banking_mode_reg;

    logic       ram_enabled_next;
    logic [4:0] low_rom_bank_next;
    logic [1:0] upper_bank_bits_next;
    logic       banking_mode_next;

    // Input stage.
    logic              in_valid_reg;
    logic              req_type_reg;
    logic [ADDR_W-1:0] bus_address_reg;
    logic [DATA_W-1:0] write_data_reg;

    // Result stage.
    logic             out_valid_reg;
    logic             accepted_reg;
    logic             to_ram_reg;
    logic [MAP_W-1:0] mapped_address_reg;

    logic             accepted_next;
    logic             to_ram_next;
    logic [MAP_W-1:0] mapped_address_next;

    logic out_free;
    logic advance;
    logic big_rom;
    logic multi_ram;
    logic [2:0] region;
    logic [4:0] bank_write;

    // Pipeline flow control.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - MAP_W){1'b0}}, mapped_address_reg};
    assign m_axis_tuser  = {to_ram_reg, accepted_reg};

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bank_count_reg <= ROM_COUNT_RESET;
            ram_bank_count_reg <= RAM_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROM_BANK_COUNT: rom_bank_count_reg <= cfg_data[ROM_COUNT_W-1:0];
                CFG_RAM_BANK_COUNT: ram_bank_count_reg <= cfg_data[RAM_COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            req_type_reg    <= s_axis_tuser;
            bus_address_reg <= s_axis_tdata[ADDR_W-1:0];
            write_data_reg  <= s_axis_tdata[ADDR_W +: DATA_W];
        end
    end

    assign region     = bus_address_reg[15:13];
    assign big_rom    = rom_bank_count_reg > ROM_COUNT_SMALL_MAX;
    assign multi_ram  = ram_bank_count_reg > RAM_COUNT_SMALL_MAX;
    assign bank_write = (write_data_reg[4:0] == 5'd0) ? 5'd1 : write_data_reg[4:0];

    // Decode the access, update bank state and form the translated address.
    always_comb
    begin
        ram_enabled_next     = ram_enabled_reg;
        low_rom_bank_next    = low_rom_bank_reg;
        upper_bank_bits_next = upper_bank_bits_reg;
        banking_mode_next    = banking_mode_reg;
        accepted_next        = 1'b0;
        to_ram_next          = 1'b0;
        mapped_address_next  = '0;

        if (!bus_address_reg[15])
        begin
            accepted_next = 1'b1;
            if (req_type_reg == REQ_WRITE)
            begin
                case (region)
                    REGION_RAM_ENABLE:
                        ram_enabled_next = (write_data_reg[3:0] == RAM_ENABLE_KEY);
                    REGION_ROM_BANK:
                        low_rom_bank_next = bank_write;
                    REGION_UPPER_BANK:
                        upper_bank_bits_next = write_data_reg[1:0];
                    REGION_MODE:
                        banking_mode_next = write_data_reg[0];
                    default:
                    begin
                    end
                endcase
            end
            else if (!bus_address_reg[14])
            begin
                // Fixed bank area: upper bits apply only in mode 1 on large carts.
                mapped_address_next = {
                    (banking_mode_reg && big_rom) ? upper_bank_bits_reg : 2'b00,
                    5'd0,
                    bus_address_reg[13:0]
                };
            end
            else
            begin
                // Switchable bank area.
                mapped_address_next = {
                    big_rom ? upper_bank_bits_reg : 2'b00,
                    low_rom_bank_reg,
                    bus_address_reg[13:0]
                };
            end
        end
        else if (region == REGION_EXT_RAM && ram_enabled_reg)
        begin
            // External RAM, same rule for reads and writes.
            accepted_next       = 1'b1;
            to_ram_next         = 1'b1;
            mapped_address_next = {
                6'd0,
                (banking_mode_reg && multi_ram) ? upper_bank_bits_reg : 2'b00,
                bus_address_reg[12:0]
            };
        end
    end

    // Bank state updates as each transaction leaves the input stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_enabled_reg     <= 1'b0;
            low_rom_bank_reg    <= 5'd1;
            upper_bank_bits_reg <= 2'd0;
            banking_mode_reg    <= 1'b0;
        end
        else if (advance)
        begin
            ram_enabled_reg     <= ram_enabled_next;
            low_rom_bank_reg    <= low_rom_bank_next;
            upper_bank_bits_reg <= upper_bank_bits_next;
            banking_mode_reg    <= banking_mode_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            accepted_reg       <= accepted_next;
            to_ram_reg         <= to_ram_next;
            mapped_address_reg <= mapped_address_next;
        end
    end

endmodule : rom_ram_bank_mapper

`default_nettype wire
